// ===== design/glow_pkg.sv =====
// Shared types, widths and constants for the glowing-disc additive shader.
// Depends on nothing; every other design file imports it.
package glow_pkg;

    // Screen size in pixels.
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;

    // Datapath widths.
    localparam int PX_W       = 7;   // pixel column and row
    localparam int COORD_W    = 10;  // signed disc center
    localparam int DXY_W      = 11;  // signed offset from the center
    localparam int SQ_W       = 20;  // one squared offset
    localparam int D2_W       = 20;  // squared distance
    localparam int RAD_W      = 8;   // core radius and glow width
    localparam int OUTER_W    = 9;   // core radius plus glow width
    localparam int CORE2_W    = 16;  // core radius squared
    localparam int R2_W       = 18;  // outer radius squared and ring span
    localparam int LEVEL_W    = 8;   // intensity
    localparam int NUM_W      = R2_W + LEVEL_W;  // dividend of the falloff division
    localparam int COLOR_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Pipeline stage counts per section.
    localparam int FRONT_STAGES = 5;
    localparam int DIV_STAGES   = LEVEL_W;  // one quotient bit per stage
    localparam int BLEND_STAGES = 2;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + BLEND_STAGES;

    // RGB565 field layout and limits.
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 5;
    localparam logic [4:0]         CH5_MAX    = 5'h1F;
    localparam logic [5:0]         CH6_MAX    = 6'h3F;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CORE_RADIUS = 3'd2,
        REG_GLOW_WIDTH  = 3'd3,
        REG_GLOW_COLOR  = 3'd4
    } glow_cfg_idx_t;

    // Input pixel request.
    typedef struct packed {
        logic [PX_W-1:0]    pixel_x;
        logic [PX_W-1:0]    pixel_y;
        logic [COLOR_W-1:0] old_color;
    } glow_pix_t;

    // Shaded pixel result.
    typedef struct packed {
        logic [COLOR_W-1:0] new_color;
        logic               touched;
    } glow_res_t;

    // Disc geometry as seen by the distance section.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                      enable;
        logic [CORE2_W-1:0]        core2;
        logic [R2_W-1:0]           outer2;
    } glow_geom_t;

    // Per-pixel sideband that rides along the division.
    typedef struct packed {
        logic [COLOR_W-1:0] old_color;
        logic               hit;
        logic               in_core;
    } glow_side_t;

endpackage

// ===== design/glow_disc_additive_shader_unit.sv =====
// Glowing-disc additive shader: shades one RGB565 pixel per clock while the output is not
// stalled, through a 15-stage pipeline of which 8 stages are the one-bit-per-stage falloff
// divider. Bubbles close up under a stalled output, so requests keep being taken until
// every stage holds a pixel. Configuration writes are taken in any cycle (cfg_ready is
// always high) and must only be made while the pipeline is empty; the derived radius
// terms are registered from the configuration registers, the ring span from those in turn.
// Depends on glow_pkg, glow_front, glow_div and glow_blend.
module glow_disc_additive_shader_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  glow_pkg::glow_pix_t             pix_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output glow_pkg::glow_res_t             res_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [glow_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [glow_pkg::CFG_DATA_W-1:0] cfg_data
);
    import glow_pkg::*;

    localparam logic [NUM_STAGES-1:0] ALL_VALID = '1;

    // Configuration registers and derived terms.
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic [RAD_W-1:0]          core_radius_reg;
    logic [RAD_W-1:0]          glow_width_reg;
    logic [COLOR_W-1:0]        glow_color_reg;
    logic [CORE2_W-1:0]        core2_reg;
    logic [R2_W-1:0]           outer2_reg;
    logic [R2_W-1:0]           ring2_reg;
    logic [OUTER_W-1:0]        outer;

    // Pipeline control.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] rdy;

    glow_geom_t         geom;
    logic [NUM_W-1:0]   num;
    glow_side_t         front_side;
    logic [LEVEL_W-1:0] quot;
    glow_side_t         div_side;

    // Configuration write port.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg          <= 10'sd64;
            cy_reg          <= 10'sd64;
            core_radius_reg <= '0;
            glow_width_reg  <= '0;
            glow_color_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CENTER_X:    cx_reg          <= $signed(cfg_data[COORD_W-1:0]);
                REG_CENTER_Y:    cy_reg          <= $signed(cfg_data[COORD_W-1:0]);
                REG_CORE_RADIUS: core_radius_reg <= cfg_data[RAD_W-1:0];
                REG_GLOW_WIDTH:  glow_width_reg  <= cfg_data[RAD_W-1:0];
                REG_GLOW_COLOR:  glow_color_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Squared radii and ring span, recomputed from the registers.
    assign outer = OUTER_W'(core_radius_reg) + OUTER_W'(glow_width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core2_reg  <= '0;
            outer2_reg <= '0;
            ring2_reg  <= '0;
        end
        else
        begin
            core2_reg  <= core_radius_reg * core_radius_reg;
            outer2_reg <= outer * outer;
            ring2_reg  <= outer2_reg - R2_W'(core2_reg);
        end
    end

    // A stage may load when some stage at or after it is empty or the output moves.
    always_comb
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            rdy[i] = !res_stall || ((valid_reg >> i) != (ALL_VALID >> i));
        end
    end

    // The first stage takes the input; every later stage takes its predecessor.
    always_comb
    begin
        valid_next[0] = rdy[0] ? pix_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (!rdy[i])
            begin
                valid_next[i] = valid_reg[i];
            end
            else
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pix_stall = !rdy[0];
    assign res_valid = valid_reg[NUM_STAGES-1];

    // Datapath sections.
    assign geom = '{cx: cx_reg, cy: cy_reg, enable: core_radius_reg != '0,
                    core2: core2_reg, outer2: outer2_reg};

    glow_front u_front (
        .clk  (clk),
        .en   (rdy[FRONT_STAGES-1:0]),
        .pix  (pix_data),
        .geom (geom),
        .num  (num),
        .side (front_side)
    );

    glow_div u_div (
        .clk      (clk),
        .en       (rdy[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
        .num      (num),
        .den      (ring2_reg),
        .side_in  (front_side),
        .quot     (quot),
        .side_out (div_side)
    );

    glow_blend u_blend (
        .clk   (clk),
        .en    (rdy[NUM_STAGES-1:FRONT_STAGES+DIV_STAGES]),
        .quot  (quot),
        .side  (div_side),
        .color (glow_color_reg),
        .res   (res_data)
    );

`ifndef SYNTHESIS
    // A request is refused only when every stage holds a pixel.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (valid_reg == ALL_VALID))
        else $error("pixel request refused while a pipeline stage is empty");

    // Nothing is drawn with a zero core radius.
    a_touch_needs_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.touched) |-> (core_radius_reg != '0))
        else $error("pixel touched with zero core radius");

    // A result held by the stalled output stays in the last stage.
    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> valid_reg[NUM_STAGES-1])
        else $error("stalled result dropped from the last stage");
`endif

endmodule

// ===== design/glow_front.sv =====
// Distance section: pixel offset, squares, squared distance, ring tests and dividend.
// Depends on glow_pkg; stage enables come from the top level.
module glow_front (
    input  logic                              clk,
    input  logic [glow_pkg::FRONT_STAGES-1:0] en,
    input  glow_pkg::glow_pix_t               pix,
    input  glow_pkg::glow_geom_t              geom,
    output logic [glow_pkg::NUM_W-1:0]        num,
    output glow_pkg::glow_side_t              side
);
    import glow_pkg::*;

    logic signed [DXY_W-1:0]   px_s;
    logic signed [DXY_W-1:0]   py_s;
    logic signed [DXY_W-1:0]   cx_s;
    logic signed [DXY_W-1:0]   cy_s;
    logic                      on_screen;
    logic signed [2*DXY_W-1:0] dx_sq;
    logic signed [2*DXY_W-1:0] dy_sq;
    logic                      in_outer;
    logic                      in_core;

    logic signed [DXY_W-1:0] dx_reg;
    logic signed [DXY_W-1:0] dy_reg;
    logic [SQ_W-1:0]         dx2_reg;
    logic [SQ_W-1:0]         dy2_reg;
    logic [D2_W-1:0]         d2_reg;
    logic [R2_W-1:0]         diff_reg;
    logic [NUM_W-1:0]        num_reg;
    glow_side_t              side0_reg;
    glow_side_t              side1_reg;
    glow_side_t              side2_reg;
    glow_side_t              side3_reg;
    glow_side_t              side4_reg;

    // Offset of the pixel from the disc center.
    assign px_s      = $signed({{(DXY_W-PX_W){1'b0}}, pix.pixel_x});
    assign py_s      = $signed({{(DXY_W-PX_W){1'b0}}, pix.pixel_y});
    assign cx_s      = DXY_W'(geom.cx);
    assign cy_s      = DXY_W'(geom.cy);
    assign on_screen = (int'(pix.pixel_x) < SCREEN_WIDTH) && (int'(pix.pixel_y) < SCREEN_HEIGHT);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg    <= px_s - cx_s;
            dy_reg    <= py_s - cy_s;
            side0_reg <= '{old_color: pix.old_color, hit: geom.enable && on_screen,
                           in_core: 1'b0};
        end
    end

    // Squares of both offsets.
    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dx2_reg   <= SQ_W'(dx_sq);
            dy2_reg   <= SQ_W'(dy_sq);
            side1_reg <= side0_reg;
        end
    end

    // Squared distance.
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            d2_reg    <= dx2_reg + dy2_reg;
            side2_reg <= side1_reg;
        end
    end

    // Core and outer tests, and the distance into the ring.
    assign in_outer = d2_reg <= D2_W'(geom.outer2);
    assign in_core  = d2_reg <= D2_W'(geom.core2);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            diff_reg  <= R2_W'(d2_reg - D2_W'(geom.core2));
            side3_reg <= '{old_color: side2_reg.old_color, hit: side2_reg.hit && in_outer,
                           in_core: in_core};
        end
    end

    // Dividend of the falloff: ring distance times full intensity.
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            num_reg   <= NUM_W'({diff_reg, {LEVEL_W{1'b0}}}) - NUM_W'(diff_reg);
            side4_reg <= side3_reg;
        end
    end

    assign num  = num_reg;
    assign side = side4_reg;

endmodule

// ===== design/glow_div.sv =====
// Pipelined restoring divider for the glow falloff, one quotient bit per stage.
// Depends on glow_pkg; the quotient is valid whenever it fits in LEVEL_W bits.
module glow_div (
    input  logic                            clk,
    input  logic [glow_pkg::DIV_STAGES-1:0] en,
    input  logic [glow_pkg::NUM_W-1:0]      num,
    input  logic [glow_pkg::R2_W-1:0]       den,
    input  glow_pkg::glow_side_t            side_in,
    output logic [glow_pkg::LEVEL_W-1:0]    quot,
    output glow_pkg::glow_side_t            side_out
);
    import glow_pkg::*;

    logic [NUM_W-1:0]   rem_reg  [DIV_STAGES];
    logic [LEVEL_W-1:0] q_reg    [DIV_STAGES];
    glow_side_t         side_reg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_step
        localparam int BIT = DIV_STAGES - 1 - j;

        logic [NUM_W-1:0]   rem_in;
        logic [LEVEL_W-1:0] q_in;
        glow_side_t         s_in;
        logic [NUM_W-1:0]   trial;
        logic [NUM_W-1:0]   rem_next;
        logic [LEVEL_W-1:0] q_next;

        // Previous stage, or the section input for the first step.
        if (j == 0)
        begin : g_first
            assign rem_in = num;
            assign q_in   = '0;
            assign s_in   = side_in;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign s_in   = side_reg[j-1];
        end

        // Try to subtract the shifted divisor for this quotient bit.
        assign trial = NUM_W'(den) << BIT;

        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                q_next   = q_in | (LEVEL_W'(1) << BIT);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                side_reg[j] <= s_in;
            end
        end
    end

    assign quot     = q_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule

// ===== design/glow_blend.sv =====
// Blend section: intensity, per-channel color scaling and saturating add.
// Depends on glow_pkg; takes the quotient and sideband from glow_div.
module glow_blend (
    input  logic                              clk,
    input  logic [glow_pkg::BLEND_STAGES-1:0] en,
    input  logic [glow_pkg::LEVEL_W-1:0]      quot,
    input  glow_pkg::glow_side_t              side,
    input  logic [glow_pkg::COLOR_W-1:0]      color,
    output glow_pkg::glow_res_t               res
);
    import glow_pkg::*;

    // Exact x / 255 for x below 16320 (64 * 255), where the quotient fits in 6 bits.
    function automatic logic [5:0] div255(input logic [13:0] x);
        logic [14:0] t;
        t = 15'(x) + 15'(x >> 8) + 15'd1;
        return 6'(t >> 8);
    endfunction

    logic [LEVEL_W-1:0] level;
    logic [4:0]         r_scaled;
    logic [5:0]         g_scaled;
    logic [4:0]         b_scaled;
    logic [5:0]         r_sum;
    logic [6:0]         g_sum;
    logic [5:0]         b_sum;
    logic [4:0]         r_sat;
    logic [5:0]         g_sat;
    logic [4:0]         b_sat;

    logic [12:0]        r_prod_reg;
    logic [13:0]        g_prod_reg;
    logic [12:0]        b_prod_reg;
    logic [COLOR_W-1:0] old_reg;
    logic               hit_reg;
    glow_res_t          res_reg;

    // Full intensity in the core, linear falloff in the ring.
    assign level = side.in_core ? LEVEL_FULL : LEVEL_FULL - quot;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_prod_reg <= color[RED_LSB +: 5] * level;
            g_prod_reg <= color[GREEN_LSB +: 6] * level;
            b_prod_reg <= color[4:0] * level;
            old_reg    <= side.old_color;
            hit_reg    <= side.hit;
        end
    end

    // Scale down by 255 and add to the old pixel with saturation.
    assign r_scaled = 5'(div255(14'(r_prod_reg)));
    assign g_scaled = div255(g_prod_reg);
    assign b_scaled = 5'(div255(14'(b_prod_reg)));
    assign r_sum    = 6'(old_reg[RED_LSB +: 5]) + 6'(r_scaled);
    assign g_sum    = 7'(old_reg[GREEN_LSB +: 6]) + 7'(g_scaled);
    assign b_sum    = 6'(old_reg[4:0]) + 6'(b_scaled);
    assign r_sat    = r_sum[5] ? CH5_MAX : r_sum[4:0];
    assign g_sat    = g_sum[6] ? CH6_MAX : g_sum[5:0];
    assign b_sat    = b_sum[5] ? CH5_MAX : b_sum[4:0];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            res_reg.new_color <= hit_reg ? {r_sat, g_sat, b_sat} : old_reg;
            res_reg.touched   <= hit_reg;
        end
    end

    assign res = res_reg;

endmodule
